// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lzce_pkg.sv
// Package for the Laplacian zero-crossing edge unit: sizes, codes and stage types.
`default_nettype none

package lzce_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;

    localparam int GRAY_W     = 8;
    localparam int LAP_W      = 11;
    localparam int PROD_W     = 2 * LAP_W;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int THR_W      = 10;
    localparam int THR_SQ_W   = 2 * THR_W;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int HLAST_W    = $clog2(MAX_HEIGHT);
    // rows run past the frame by three while the pipeline drains
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 3);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int W_RESET    = 640;
    localparam int H_RESET    = 480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZC_THRESHOLD = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_pos;

    typedef struct packed {
        logic lap_go;
        logic out_go;
        logic out_int;
        logic fend;
    } t_ctl;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic [COL_W-1:0]  gcol;
        logic [COL_W-1:0]  lcol;
        logic              lap_int;
        t_ctl              ctl;
    } t_s1;

    typedef struct packed {
        logic signed [LAP_W-1:0] lv;
        logic [COL_W-1:0]        lcol;
        t_ctl                    ctl;
    } t_s2;

endpackage

`default_nettype wire

// File: rtl/core/lzce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lzce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/core/laplacian_zero_crossing_edges_unit.sv
// Top level of the Laplacian zero-crossing edge unit: line buffers, windows and pipeline.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_command, i_gray_pixel
//  out     | output    | o_out_valid / i_out_ready | o_edge_mark, o_laplacian_value, o_frame_end
//  cfg     | input     | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// One item per clock sustained while the output takes results; after its item is taken, a result
// passes the gray line-buffer read, the Laplacian line-buffer read and the output register.
// The rate is set by the single read port of each line-buffer RAM, one access per item.
// Synchronous reset clears positions and valid bits and loads the configuration defaults; the line buffers are not
// cleared and need no clearing pass. A stalled output holds only the stages behind it
// that are full; an empty stage still takes a new item.
`default_nettype none

`include "assert_macros.svh"

module laplacian_zero_crossing_edges_unit
    import lzce_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_command,
    input  wire logic [GRAY_W-1:0]       i_gray_pixel,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_edge_mark,
    output logic signed [LAP_W-1:0]      o_laplacian_value,
    output logic                         o_frame_end,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration, held as last column / last row
    logic [COL_W-1:0]    r_w_last;
    logic [HLAST_W-1:0]  r_h_last;
    logic [THR_SQ_W-1:0] r_thr_sq;

    // stream positions: incoming pixel, Laplacian, result
    t_pos r_in, r_lap, r_out;
    t_pos n_in, n_lap, n_out;

    logic r_s1_valid, r_s2_valid, r_out_valid;
    t_s1  r_s1, n_s1;
    t_s2  r_s2;

    // windows: only the taps that feed later arithmetic
    logic [GRAY_W-1:0]       r_gw_ctr, r_gw_top, r_gw_mid, r_gw_bot;
    logic signed [LAP_W-1:0] r_lw_ctr, r_lw_top, r_lw_mid, r_lw_bot;

    logic                    r_edge;
    logic signed [LAP_W-1:0] r_lv_out;
    logic                    r_fend;

    logic [2*GRAY_W-1:0] gray_rd;
    logic [2*LAP_W-1:0]  lap_rd;

    logic accept, step, in_frame, lap_go, out_go, fend;
    logic s1_adv, s2_adv, out_free;

    logic signed [11:0]       lap_sum;
    logic signed [LAP_W-1:0]  lv_next;
    logic signed [LAP_W-1:0]  lap_rd_mid;
    logic signed [PROD_W-1:0] prod_h, prod_v;
    logic signed [PROD_W:0]   diff_h, diff_v;
    logic                     edge_next;

    logic [FW_W-1:0]    cfg_fw;
    logic [FH_W-1:0]    cfg_fh;
    logic [THR_W-1:0]   cfg_thr;
    logic [COL_W-1:0]   cfg_w_last;
    logic [HLAST_W-1:0] cfg_h_last;

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_adv     = r_s2_valid && (!r_s2.ctl.out_go || out_free);
    assign s1_adv     = r_s1_valid && (!r_s2_valid || s2_adv);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // drain items inside the frame are dropped; after the frame any item drains
    assign in_frame = r_in.row <= ROW_W'(r_h_last);
    assign step     = accept && !(in_frame && (i_command == CMD_DRAIN));

    assign lap_go = (r_in.row >= ROW_W'(2)) || ((r_in.row == ROW_W'(1)) && (r_in.col != '0));
    assign out_go = (r_in.row >= ROW_W'(3)) || ((r_in.row == ROW_W'(2)) && (r_in.col >= COL_W'(2)));
    assign fend   = out_go && (r_out.row == ROW_W'(r_h_last)) && (r_out.col == r_w_last);

    function automatic t_pos pos_inc(input t_pos p, input logic [COL_W-1:0] w_last);
        t_pos q;
        q = p;
        if (p.col == w_last) begin
            q.col = '0;
            q.row = p.row + 1'b1;
        end else begin
            q.col = p.col + 1'b1;
        end
        return q;
    endfunction

    function automatic logic interior(input t_pos p, input logic [COL_W-1:0] w_last,
                                      input logic [HLAST_W-1:0] h_last);
        return (p.row != '0) && (p.row < ROW_W'(h_last)) && (p.col != '0) && (p.col < w_last);
    endfunction

    always_comb begin
        n_in  = r_in;
        n_lap = r_lap;
        n_out = r_out;
        n_s1.gray        = (in_frame) ? i_gray_pixel : '0;
        n_s1.gcol        = r_in.col;
        n_s1.lcol        = r_lap.col;
        n_s1.lap_int     = interior(r_lap, r_w_last, r_h_last);
        n_s1.ctl.lap_go  = lap_go;
        n_s1.ctl.out_go  = out_go;
        n_s1.ctl.out_int = interior(r_out, r_w_last, r_h_last);
        n_s1.ctl.fend    = fend;
        if (step) begin
            n_in = pos_inc(r_in, r_w_last);
            if (lap_go) begin
                n_lap = pos_inc(r_lap, r_w_last);
            end
            if (out_go) begin
                n_out = pos_inc(r_out, r_w_last);
            end
            if (fend) begin
                n_in  = '0;
                n_lap = '0;
                n_out = '0;
            end
        end
        if (i_cfg_wr_en && ((i_cfg_index == CFG_FRAME_WIDTH) ||
                            (i_cfg_index == CFG_FRAME_HEIGHT))) begin
            n_in  = '0;
            n_lap = '0;
            n_out = '0;
        end
    end

    // configuration clamping
    assign cfg_fw  = i_cfg_data[FW_W-1:0];
    assign cfg_fh  = i_cfg_data[FH_W-1:0];
    assign cfg_thr = i_cfg_data[THR_W-1:0];

    always_comb begin
        if (int'(cfg_fw) < MIN_DIM) begin
            cfg_w_last = COL_W'(MIN_DIM - 1);
        end else if (int'(cfg_fw) > MAX_WIDTH) begin
            cfg_w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            cfg_w_last = COL_W'(cfg_fw - 1'b1);
        end
        if (int'(cfg_fh) < MIN_DIM) begin
            cfg_h_last = HLAST_W'(MIN_DIM - 1);
        end else if (int'(cfg_fh) > MAX_HEIGHT) begin
            cfg_h_last = HLAST_W'(MAX_HEIGHT - 1);
        end else begin
            cfg_h_last = HLAST_W'(cfg_fh - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= COL_W'(W_RESET - 1);
            r_h_last <= HLAST_W'(H_RESET - 1);
            r_thr_sq <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_w_last <= cfg_w_last;
                CFG_FRAME_HEIGHT: r_h_last <= cfg_h_last;
                CFG_ZC_THRESHOLD: r_thr_sq <= THR_SQ_W'(cfg_thr * cfg_thr);
                default: ;
            endcase
        end
    end

    // gray line buffers: {oldest, middle} per column
    lzce_ram #(
        .WIDTH (2 * GRAY_W),
        .DEPTH (MAX_WIDTH)
    ) u_gray_rows (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1.gcol),
        .i_wr_data ({gray_rd[GRAY_W-1:0], r_s1.gray}),
        .i_rd_en   (step),
        .i_rd_addr (r_in.col),
        .o_rd_data (gray_rd)
    );

    // Laplacian of the window after this item's shift
    assign lap_sum = $signed({2'b00, r_gw_mid, 2'b00})
                   - $signed({4'b0000, r_gw_ctr})
                   - $signed({4'b0000, gray_rd[GRAY_W-1:0]})
                   - $signed({4'b0000, r_gw_top})
                   - $signed({4'b0000, r_gw_bot});
    assign lv_next = r_s1.lap_int ? lap_sum[LAP_W-1:0] : '0;

    lzce_ram #(
        .WIDTH (2 * LAP_W),
        .DEPTH (MAX_WIDTH)
    ) u_lap_rows (
        .i_clk     (i_clk),
        .i_wr_en   (s2_adv && r_s2.ctl.lap_go),
        .i_wr_addr (r_s2.lcol),
        .i_wr_data ({lap_rd[LAP_W-1:0], r_s2.lv}),
        .i_rd_en   (s1_adv),
        .i_rd_addr (r_s1.lcol),
        .o_rd_data (lap_rd)
    );

    // crossing test on the Laplacian window after this item's shift
    assign lap_rd_mid = lap_rd[LAP_W-1:0];
    assign prod_h     = r_lw_ctr * lap_rd_mid;
    assign prod_v     = r_lw_top * r_lw_bot;
    assign diff_h     = $signed({prod_h[PROD_W-1], prod_h})
                      + $signed({{(PROD_W + 1 - THR_SQ_W){1'b0}}, r_thr_sq});
    assign diff_v     = $signed({prod_v[PROD_W-1], prod_v})
                      + $signed({{(PROD_W + 1 - THR_SQ_W){1'b0}}, r_thr_sq});
    assign edge_next  = r_s2.ctl.out_int && (diff_h[PROD_W] || diff_v[PROD_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in        <= '0;
            r_lap       <= '0;
            r_out       <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in  <= n_in;
            r_lap <= n_lap;
            r_out <= n_out;
            if (o_in_ready) begin
                r_s1_valid <= step;
            end
            if (!r_s2_valid || s2_adv) begin
                r_s2_valid <= s1_adv;
            end
            if (s2_adv && r_s2.ctl.out_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_gw_ctr  <= r_gw_mid;
            r_gw_top  <= gray_rd[2*GRAY_W-1:GRAY_W];
            r_gw_mid  <= gray_rd[GRAY_W-1:0];
            r_gw_bot  <= r_s1.gray;
            r_s2.lv   <= lv_next;
            r_s2.lcol <= r_s1.lcol;
            r_s2.ctl  <= r_s1.ctl;
        end
        if (s2_adv && r_s2.ctl.lap_go) begin
            r_lw_ctr <= r_lw_mid;
            r_lw_top <= lap_rd[2*LAP_W-1:LAP_W];
            r_lw_mid <= lap_rd_mid;
            r_lw_bot <= r_s2.lv;
        end
        if (s2_adv && r_s2.ctl.out_go) begin
            r_edge   <= edge_next;
            r_lv_out <= r_s2.ctl.out_int ? r_lw_mid : '0;
            r_fend   <= r_s2.ctl.fend;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_edge_mark       = r_edge;
    assign o_laplacian_value = r_lv_out;
    assign o_frame_end       = r_fend;

    `ASSERT_NEXT(a_fend_restart, i_clk, i_rst_n, step && fend, (r_in == '0) && (r_out == '0), "positions not cleared after the last item of a frame")
    `ASSERT_HOLD(a_out_row_in_frame, i_clk, i_rst_n, r_out.row <= ROW_W'(r_h_last), "result position beyond the frame")
    `ASSERT_HOLD(a_s2_stall_cause, i_clk, i_rst_n, !(r_s2_valid && !s2_adv) || (r_out_valid && !i_out_ready), "Laplacian stage held without output back-pressure")

endmodule

`default_nettype wire

// File: tb/tb_laplacian_zero_crossing_edges_unit.sv
// Self-checking testbench for the Laplacian zero-crossing edge unit, with its own line-buffer predictor.
module tb_laplacian_zero_crossing_edges_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lzce_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                    edge_mark;
        logic signed [LAP_W-1:0] lap;
        logic                    fend;
    } edge_res_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_wr_t;

    typedef struct packed {
        logic              cmd;
        logic [GRAY_W-1:0] pix;
        logic              has_mark;
        edge_res_t         mark;
    } dir_row_t;

    localparam edge_res_t BORDER_MARK = '0;
    localparam edge_res_t CENTRE_MARK = '{edge_mark: 1'b0, lap: 11'sd1020, fend: 1'b0};
    localparam edge_res_t LAST_MARK   = '{edge_mark: 1'b0, lap: 11'sd0, fend: 1'b1};

    // 3x3 frame: the only interior pixel is bright on a dark cross, so L = +1020 there
    localparam dir_row_t DIR_ROWS [19] = '{
        '{CMD_DRAIN, 8'h00, 1'b0, BORDER_MARK},  // drain while pixels are due: ignored
        '{CMD_PIXEL, 8'hff, 1'b0, BORDER_MARK},
        '{CMD_PIXEL, 8'h00, 1'b0, BORDER_MARK},
        '{CMD_PIXEL, 8'hff, 1'b0, BORDER_MARK},
        '{CMD_PIXEL, 8'h00, 1'b0, BORDER_MARK},
        '{CMD_PIXEL, 8'hff, 1'b0, BORDER_MARK},
        '{CMD_PIXEL, 8'h00, 1'b0, BORDER_MARK},
        '{CMD_PIXEL, 8'hff, 1'b0, BORDER_MARK},
        '{CMD_PIXEL, 8'h00, 1'b0, BORDER_MARK},
        '{CMD_PIXEL, 8'h00, 1'b1, BORDER_MARK},
        '{CMD_PIXEL, 8'hff, 1'b1, BORDER_MARK},  // pixel past the frame acts as a drain
        '{CMD_DRAIN, 8'h00, 1'b1, BORDER_MARK},
        '{CMD_DRAIN, 8'h5a, 1'b1, BORDER_MARK},
        '{CMD_DRAIN, 8'h00, 1'b1, CENTRE_MARK},
        '{CMD_DRAIN, 8'h00, 1'b1, BORDER_MARK},
        '{CMD_DRAIN, 8'h00, 1'b1, BORDER_MARK},
        '{CMD_DRAIN, 8'h00, 1'b1, BORDER_MARK},
        '{CMD_DRAIN, 8'h00, 1'b1, LAST_MARK},
        '{CMD_DRAIN, 8'h00, 1'b0, BORDER_MARK}   // after frame end: ignored
    };

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_command = CMD_PIXEL;
    logic [GRAY_W-1:0]            i_gray_pixel = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic                         o_edge_mark;
    logic signed [LAP_W-1:0]      o_laplacian_value;
    logic                         o_frame_end;
    logic                         i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;

    // predictor state
    logic [FW_W-1:0]              cfg_width = FW_W'(W_RESET);
    logic [FH_W-1:0]              cfg_height = FH_W'(H_RESET);
    logic [THR_W-1:0]             cfg_thr = '0;
    logic [GRAY_W-1:0]            gray_line [2*MAX_WIDTH] = '{default: '0};
    logic signed [LAP_W-1:0]      lap_line [2*MAX_WIDTH] = '{default: '0};
    logic [GRAY_W-1:0]            gwin [9] = '{default: '0};
    logic signed [LAP_W-1:0]      lwin [9] = '{default: '0};
    int unsigned                  pix_seen = 0;
    int unsigned                  marks_out = 0;

    edge_res_t                    pending_marks [$];
    reg_wr_t                      reg_writes [$];
    bit                           calm = 1'b0;
    int                           n_errors = 0;

    laplacian_zero_crossing_edges_unit u_top (.*);

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 7);
    end

    function automatic int frame_w();
        if (cfg_width < MIN_DIM) return MIN_DIM;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    function automatic int frame_h();
        if (cfg_height < MIN_DIM) return MIN_DIM;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(cfg_height);
    endfunction

    function automatic bit inner(int row, int col, int w, int h);
        return row >= 1 && row + 1 < h && col >= 1 && col + 1 < w;
    endfunction

    // Advances the predictor by one item; returns 1 when the item releases a result.
    function automatic bit predict_edge(input logic cmd, input logic [GRAY_W-1:0] pix,
                                        output edge_res_t res);
        int w, h, n, c, m, cm, e, lim, lv, k;
        bit in_frame;
        logic [GRAY_W-1:0] g, g_old, g_mid;
        logic signed [LAP_W-1:0] l_old, l_mid;
        w = frame_w();
        h = frame_h();
        res = '0;
        in_frame = pix_seen < w * h;
        if (in_frame && cmd == CMD_DRAIN) return 1'b0;
        g = in_frame ? pix : '0;
        n = pix_seen;
        c = n % w;

        g_old = gray_line[MAX_WIDTH + c];
        g_mid = gray_line[c];
        gray_line[MAX_WIDTH + c] = g_mid;
        gray_line[c] = g;
        for (k = 0; k < 3; k++) begin
            gwin[k*3]     = gwin[k*3 + 1];
            gwin[k*3 + 1] = gwin[k*3 + 2];
        end
        gwin[2] = g_old;
        gwin[5] = g_mid;
        gwin[8] = g;

        // Laplacian runs one line plus one pixel behind the input
        if (n >= w + 1) begin
            m = n - w - 1;
            cm = m % w;
            lv = 0;
            if (inner(m / w, cm, w, h))
                lv = 4 * int'(gwin[4]) - int'(gwin[3]) - int'(gwin[5])
                     - int'(gwin[1]) - int'(gwin[7]);
            l_old = lap_line[MAX_WIDTH + cm];
            l_mid = lap_line[cm];
            lap_line[MAX_WIDTH + cm] = l_mid;
            lap_line[cm] = LAP_W'(lv);
            for (k = 0; k < 3; k++) begin
                lwin[k*3]     = lwin[k*3 + 1];
                lwin[k*3 + 1] = lwin[k*3 + 2];
            end
            lwin[2] = l_old;
            lwin[5] = l_mid;
            lwin[8] = LAP_W'(lv);
        end

        if (n >= 2 * w + 2) begin
            e = marks_out;
            if (inner(e / w, e % w, w, h)) begin
                lim = -int'(cfg_thr) * int'(cfg_thr);
                res.lap = lwin[4];
                res.edge_mark = (int'(lwin[3]) * int'(lwin[5]) < lim) ||
                                (int'(lwin[1]) * int'(lwin[7]) < lim);
            end
            res.fend = (e + 1 == w * h);
            marks_out = e + 1;
            if (res.fend) begin
                pix_seen = 0;
                marks_out = 0;
            end else begin
                pix_seen = n + 1;
            end
            return 1'b1;
        end
        pix_seen = n + 1;
        return 1'b0;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic drive_item(input logic cmd, input logic [GRAY_W-1:0] pix);
        while (!calm && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_gray_pixel <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_marks.size() != 0) @(negedge i_clk);
        // items that give no result may still be in the pipeline
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_regs();
        reg_wr_t wr;
        while (reg_writes.size() != 0) begin
            wr = reg_writes.pop_front();
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= wr.idx;
            i_cfg_data  <= wr.data;
            case (wr.idx)
                CFG_FRAME_WIDTH: begin
                    cfg_width = wr.data[FW_W-1:0];
                    pix_seen = 0;
                    marks_out = 0;
                end
                CFG_FRAME_HEIGHT: begin
                    cfg_height = wr.data[FH_W-1:0];
                    pix_seen = 0;
                    marks_out = 0;
                end
                CFG_ZC_THRESHOLD: cfg_thr = wr.data[THR_W-1:0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        edge_res_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_marks.size() == 0) begin
                $error("result with nothing expected: edge_mark %0d laplacian_value %0d",
                       o_edge_mark, o_laplacian_value);
                n_errors++;
            end else begin
                want = pending_marks.pop_front();
                if (o_edge_mark !== want.edge_mark) begin
                    $error("edge_mark: expected %0d, got %0d", want.edge_mark, o_edge_mark);
                    n_errors++;
                end
                if (o_laplacian_value !== want.lap) begin
                    $error("laplacian_value: expected %0d, got %0d",
                           want.lap, o_laplacian_value);
                    n_errors++;
                end
                if (o_frame_end !== want.fend) begin
                    $error("frame_end: expected %0d, got %0d", want.fend, o_frame_end);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        edge_res_t res;
        logic cmd;
        logic [GRAY_W-1:0] pix;
        int phase, style, base, total, sent, abort_at, wv, hv, tv, random_items;
        bit got, skip, big;

        random_items = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // clamped geometry: width 0 and height 2 both act as 3
        reg_writes.push_back('{CFG_FRAME_WIDTH, 13'd0});
        reg_writes.push_back('{CFG_FRAME_HEIGHT, 13'd2});
        reg_writes.push_back('{CFG_ZC_THRESHOLD, 13'h03ff});
        reg_writes.push_back('{CFG_SPARE, 13'h1fff});
        write_regs();

        foreach (DIR_ROWS[i]) begin
            void'(predict_edge(DIR_ROWS[i].cmd, DIR_ROWS[i].pix, res));
            if (DIR_ROWS[i].has_mark) pending_marks.push_back(DIR_ROWS[i].mark);
            drive_item(DIR_ROWS[i].cmd, DIR_ROWS[i].pix);
        end

        phase = 0;
        while (random_items < 1800) begin
            phase++;
            wait_idle();
            big = (phase == 3 || phase == 7);
            if (big) begin
                // widest and tallest frames, both reached through clamping
                reg_writes.push_back('{CFG_FRAME_WIDTH, (phase == 3) ? 13'd2047 : 13'd0});
                reg_writes.push_back('{CFG_FRAME_HEIGHT, (phase == 3) ? 13'd0 : 13'd8191});
            end else begin
                if ($urandom_range(0, 99) < 70) begin
                    wv = $urandom_range(0, 99);
                    wv = (wv < 10) ? $urandom_range(0, 2) :
                         (wv < 85) ? $urandom_range(3, 10) : $urandom_range(11, 48);
                    reg_writes.push_back('{CFG_FRAME_WIDTH,
                                           13'(wv) | (13'($urandom_range(0, 3)) << FW_W)});
                end
                if ($urandom_range(0, 99) < 70) begin
                    hv = $urandom_range(0, 99);
                    hv = (hv < 10) ? $urandom_range(0, 2) :
                         (hv < 90) ? $urandom_range(3, 8) : $urandom_range(9, 20);
                    reg_writes.push_back('{CFG_FRAME_HEIGHT, 13'(hv)});
                end
            end
            if ($urandom_range(0, 99) < 80) begin
                tv = $urandom_range(0, 99);
                tv = (tv < 25) ? 0 : (tv < 35) ? 1020 : (tv < 40) ? 1023 :
                     $urandom_range(0, 400);
                reg_writes.push_back('{CFG_ZC_THRESHOLD,
                                       13'(tv) | (13'($urandom_range(0, 7)) << THR_W)});
            end
            if ($urandom_range(0, 99) < 10)
                reg_writes.push_back('{CFG_SPARE, 13'($urandom)});
            write_regs();

            calm = ($urandom_range(0, 99) < 20);
            style = big ? 1 : $urandom_range(0, 3);
            base = $urandom_range(0, 240);
            total = frame_w() * frame_h();
            // now and then the frame is cut short, so the next geometry write restarts it
            abort_at = (!big && $urandom_range(0, 99) < 10) ?
                       $urandom_range(1, total + 2 * frame_w() + 1) : 0;
            sent = 0;
            forever begin
                if (pix_seen < total)
                    cmd = ($urandom_range(0, 99) < 4) ? CMD_DRAIN : CMD_PIXEL;
                else
                    cmd = ($urandom_range(0, 99) < 25) ? CMD_PIXEL : CMD_DRAIN;
                case (style)
                    0: pix = GRAY_W'($urandom_range(0, 255));
                    1: pix = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    2: pix = GRAY_W'($urandom_range(base, base + 15));
                    default: pix = ($urandom_range(0, 99) < 10) ? 8'hff :
                                   GRAY_W'($urandom_range(0, 3));
                endcase
                skip = (pix_seen < total) && (cmd == CMD_DRAIN);
                got = predict_edge(cmd, pix, res);
                if (got) pending_marks.push_back(res);
                drive_item(cmd, pix);
                sent++;
                if (!skip && !big) random_items++;
                if (got && res.fend) break;
                if (abort_at != 0 && sent >= abort_at) break;
            end
            if ($urandom_range(0, 99) < 30) begin
                got = predict_edge(CMD_DRAIN, GRAY_W'($urandom_range(0, 255)), res);
                if (got) pending_marks.push_back(res);
                drive_item(CMD_DRAIN, GRAY_W'($urandom_range(0, 255)));
            end
            calm = 1'b0;
        end

        wait_idle();
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
